// ----- hw/rtl/lant_pkg.sv -----
// shared types and constants for the direction-colored langton's ant block
// used by lant_cfg and the top level; no dependencies
package lant_pkg;

  localparam int COORD_W = 8;
  localparam int SIZE_W  = 9;
  localparam int IDX_W   = 3;
  localparam int COLOR_W = 24;
  localparam int CELLS   = 65536;
  localparam int ADDR_W  = 16;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [COORD_W-1:0] ANT_RESET   = 8'd40;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 9'd256;
  localparam logic [COORD_W-1:0] START_RESET = 8'd40;

  typedef enum logic [1:0] {
    MODE_STEP    = 2'd0,
    MODE_READ    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_START_X     = 2'd2,
    REG_START_Y     = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  // effective grid size and raw start position
  typedef struct packed {
    logic [SIZE_W-1:0]  eff_w;
    logic [SIZE_W-1:0]  eff_h;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
  } cfg_t;

  function automatic logic [COLOR_W-1:0] palette(input logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      3'd0:    c = 24'hFFFFFF;
      3'd1:    c = 24'hFF00FF;
      3'd2:    c = 24'hFF0F0F;
      3'd3:    c = 24'hFFFF00;
      3'd4:    c = 24'h000000;
      3'd5:    c = 24'h00FF00;
      3'd6:    c = 24'h00F0F0;
      default: c = 24'h0000FF;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/langtons_ant_direction_colored_step_top.sv -----
// langton's ant with a direction-colored trail on a wrapping grid
// depends on lant_pkg, lant_ram, lant_cfg
//
//   port group   dir  handshake            payload
//   in           in   in_valid / in_stall  mode, read_x, read_y
//   out          out  out_valid / out_stall cell_x, cell_y, cell_color, ant_x, ant_y, ant_dir
//   apb          in   psel/penable/pready  paddr, pwdata, prdata
//
// every word is handled as a read of the cell ram, then the write-back and result
// the cell ram has one read and one write port; the next step needs this step's position
// after reset a clearing pass writes all 65536 cells white, with in_stall high
// a finished result waits in the output register while the next word is accepted
// the write-back cycle waits while that register is still full and stalled
module langtons_ant_direction_colored_step_top #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     mode,
  input  logic [7:0]                     read_x,
  input  logic [7:0]                     read_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     cell_x,
  output logic [7:0]                     cell_y,
  output logic [23:0]                    cell_color,
  output logic [7:0]                     ant_x,
  output logic [7:0]                     ant_y,
  output logic [1:0]                     ant_dir,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lant_pkg::PADDR_W-1:0]   paddr,
  input  logic [lant_pkg::PDATA_W-1:0]   pwdata,
  output logic [lant_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int CW = lant_pkg::COORD_W;
  localparam int SW = lant_pkg::SIZE_W;

  lant_pkg::cfg_t   cfg;
  lant_pkg::state_t state, state_next;

  logic [lant_pkg::ADDR_W-1:0] clr_addr;
  logic [CW-1:0]               ant_col, ant_row;
  logic [1:0]                  heading;
  lant_pkg::mode_t             op_mode;
  logic [CW-1:0]               cx, cy;
  logic [CW-1:0]               cx_next, cy_next;

  logic                        accept, load;
  logic                        ram_we, ram_re;
  logic [lant_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [lant_pkg::IDX_W-1:0]  ram_wdata, ram_rdata;

  logic [lant_pkg::IDX_W-1:0]  new_idx;
  logic [1:0]                  step_dir;
  logic [CW-1:0]               step_col, step_row;
  logic [CW-1:0]               res_col, res_row;
  logic [1:0]                  res_dir;
  logic [23:0]                 res_color;

  lant_cfg #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  lant_ram #(
    .WIDTH(lant_pkg::IDX_W),
    .DEPTH(lant_pkg::CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lant_pkg::ST_CLEAR:  if (clr_addr == '1) state_next = lant_pkg::ST_IDLE;
      lant_pkg::ST_IDLE:   if (in_valid) state_next = lant_pkg::ST_LOOKUP;
      lant_pkg::ST_LOOKUP: if (!out_valid || !out_stall) state_next = lant_pkg::ST_IDLE;
      default:             state_next = lant_pkg::ST_CLEAR;
    endcase
  end

  // state machine outputs
  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    load     = 1'b0;
    ram_we   = 1'b0;
    case (state)
      lant_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      lant_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      lant_pkg::ST_LOOKUP: begin
        load   = !out_valid || !out_stall;
        ram_we = load && (op_mode == lant_pkg::MODE_STEP);
      end
      default: ;
    endcase
  end

  // cell address of the incoming word
  always_comb begin
    case (lant_pkg::mode_t'(mode))
      lant_pkg::MODE_STEP: begin
        cx_next = ({1'b0, ant_col} >= cfg.eff_w) ? CW'(cfg.eff_w - 1'b1) : ant_col;
        cy_next = ({1'b0, ant_row} >= cfg.eff_h) ? CW'(cfg.eff_h - 1'b1) : ant_row;
      end
      lant_pkg::MODE_RESTART: begin
        cx_next = ({1'b0, cfg.start_x} >= cfg.eff_w) ? CW'(cfg.eff_w - 1'b1) : cfg.start_x;
        cy_next = ({1'b0, cfg.start_y} >= cfg.eff_h) ? CW'(cfg.eff_h - 1'b1) : cfg.start_y;
      end
      default: begin
        cx_next = read_x;
        cy_next = read_y;
      end
    endcase
  end

  assign ram_re    = accept;
  assign ram_raddr = {cy_next, cx_next};
  assign ram_waddr = (state == lant_pkg::ST_CLEAR) ? clr_addr : {cy, cx};
  assign ram_wdata = (state == lant_pkg::ST_CLEAR) ? '0 : new_idx;

  // step: flip the zero-red bit, record heading, turn and move with wrap
  always_comb begin
    new_idx  = {~ram_rdata[2], heading};
    step_dir = ram_rdata[2] ? heading + 2'd1 : heading - 2'd1;
    step_col = cx;
    step_row = cy;
    case (lant_pkg::dir_t'(step_dir))
      lant_pkg::DIR_UP:
        step_row = (cy == '0) ? CW'(cfg.eff_h - 1'b1) : cy - 1'b1;
      lant_pkg::DIR_RIGHT:
        step_col = ((SW'(cx) + 1'b1) >= cfg.eff_w) ? '0 : cx + 1'b1;
      lant_pkg::DIR_DOWN:
        step_row = ((SW'(cy) + 1'b1) >= cfg.eff_h) ? '0 : cy + 1'b1;
      default:
        step_col = (cx == '0) ? CW'(cfg.eff_w - 1'b1) : cx - 1'b1;
    endcase
  end

  always_comb begin
    case (op_mode)
      lant_pkg::MODE_STEP: begin
        res_col   = step_col;
        res_row   = step_row;
        res_dir   = step_dir;
        res_color = lant_pkg::palette(new_idx);
      end
      lant_pkg::MODE_RESTART: begin
        res_col   = cx;
        res_row   = cy;
        res_dir   = lant_pkg::DIR_UP;
        res_color = lant_pkg::palette(ram_rdata);
      end
      default: begin
        res_col   = ant_col;
        res_row   = ant_row;
        res_dir   = heading;
        res_color = lant_pkg::palette(ram_rdata);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lant_pkg::ST_CLEAR;
      clr_addr  <= '0;
      ant_col   <= lant_pkg::ANT_RESET;
      ant_row   <= lant_pkg::ANT_RESET;
      heading   <= lant_pkg::DIR_UP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lant_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load) begin
        ant_col <= res_col;
        ant_row <= res_row;
        heading <= res_dir;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= lant_pkg::mode_t'(mode);
      cx      <= cx_next;
      cy      <= cy_next;
    end
    if (load) begin
      cell_x     <= cx;
      cell_y     <= cy;
      cell_color <= res_color;
      ant_x      <= res_col;
      ant_y      <= res_row;
      ant_dir    <= res_dir;
    end
  end

  // the ram is written only by the clearing pass or a step write-back
  a_ram_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == lant_pkg::ST_CLEAR) ||
               (state == lant_pkg::ST_LOOKUP && op_mode == lant_pkg::MODE_STEP))
    else $error("cell ram written outside clear or step write-back");

  // a step always turns by exactly one quarter
  a_step_turn: assert property (@(posedge clk) disable iff (rst)
    (load && op_mode == lant_pkg::MODE_STEP) |=>
      (heading == $past(heading) + 2'd1) || (heading == $past(heading) - 2'd1))
    else $error("step did not turn by one quarter");

  // clearing pass covers the whole ram before words are taken
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == lant_pkg::ST_IDLE && $past(state) == lant_pkg::ST_CLEAR) |->
      $past(clr_addr) == '1)
    else $error("clearing pass left early");

  // a new result only comes from the write-back cycle
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == lant_pkg::ST_LOOKUP)
    else $error("result appeared without a lookup");

endmodule

// ----- hw/rtl/lant_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module lant_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/lant_cfg.sv -----
// apb register file for grid size and start position, with size clamping
// depends on lant_pkg
module lant_cfg #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lant_pkg::PADDR_W-1:0]   paddr,
  input  logic [lant_pkg::PDATA_W-1:0]   pwdata,
  output logic [lant_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output lant_pkg::cfg_t                 cfg
);

  localparam int LIM_W = (GRID_W < 256) ? GRID_W : 256;
  localparam int LIM_H = (GRID_H < 256) ? GRID_H : 256;

  logic [lant_pkg::SIZE_W-1:0]  grid_width;
  logic [lant_pkg::SIZE_W-1:0]  grid_height;
  logic [lant_pkg::COORD_W-1:0] start_x;
  logic [lant_pkg::COORD_W-1:0] start_y;
  lant_pkg::reg_t               reg_sel;
  logic                         wr;

  function automatic logic [lant_pkg::SIZE_W-1:0] eff_size(
    input logic [lant_pkg::SIZE_W-1:0] v,
    input logic [lant_pkg::SIZE_W-1:0] lim
  );
    logic [lant_pkg::SIZE_W-1:0] r;
    if (v == '0) begin
      r = lant_pkg::SIZE_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pready  = 1'b1;
  assign reg_sel = lant_pkg::reg_t'(paddr[3:2]);
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= lant_pkg::SIZE_RESET;
      grid_height <= lant_pkg::SIZE_RESET;
      start_x     <= lant_pkg::START_RESET;
      start_y     <= lant_pkg::START_RESET;
    end else if (wr) begin
      case (reg_sel)
        lant_pkg::REG_GRID_WIDTH:  grid_width  <= pwdata[lant_pkg::SIZE_W-1:0];
        lant_pkg::REG_GRID_HEIGHT: grid_height <= pwdata[lant_pkg::SIZE_W-1:0];
        lant_pkg::REG_START_X:     start_x     <= pwdata[lant_pkg::COORD_W-1:0];
        lant_pkg::REG_START_Y:     start_y     <= pwdata[lant_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lant_pkg::REG_GRID_WIDTH:  prdata = lant_pkg::PDATA_W'(grid_width);
      lant_pkg::REG_GRID_HEIGHT: prdata = lant_pkg::PDATA_W'(grid_height);
      lant_pkg::REG_START_X:     prdata = lant_pkg::PDATA_W'(start_x);
      lant_pkg::REG_START_Y:     prdata = lant_pkg::PDATA_W'(start_y);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.eff_w   = eff_size(grid_width,  lant_pkg::SIZE_W'(LIM_W));
    cfg.eff_h   = eff_size(grid_height, lant_pkg::SIZE_W'(LIM_H));
    cfg.start_x = start_x;
    cfg.start_y = start_y;
  end

endmodule
